// ===== hw/rtl/sha256_pkg.sv =====
// SHA-256 shared package: round constants, initial hash values, round functions.
// No dependencies.
package sha256_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       last;
   } in_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUNDS,
      ST_FOLD,
      ST_PAD,
      ST_LEN,
      ST_EMIT
   } core_state_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic word_type rotr(word_type v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function automatic word_type sig0(word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sig1(word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type bsig0(word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ===== hw/rtl/sha256_fifo.sv =====
// Short item queue between the accepting front and the hashing core.
// Depends on sha256_pkg.
module sha256_fifo
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_valid,
   output logic        wr_ready,
   input  in_item_type wr_item,
   output logic        rd_valid,
   input  logic        rd_ready,
   output in_item_type rd_item
);
   in_item_type slot_ff [4];
   logic [1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [2:0]  count_ff, count_in;
   logic        push, pop;

   assign wr_ready = (count_ff != 3'd4);
   assign rd_valid = (count_ff != 3'd0);
   assign rd_item  = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wptr_in  = push ? wptr_ff + 2'd1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 2'd1 : rptr_ff;
      count_in = count_ff + {2'd0, push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wptr_ff] <= wr_item;
   end
endmodule

// ===== hw/rtl/sha256_core.sv =====
// Back end: block buffer, padding sequencer, 64-round compression, digest readout.
// Depends on sha256_pkg.
module sha256_core
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   output logic        item_ready,
   input  in_item_type item,
   output logic        out_valid,
   input  logic        out_ready,
   output word_type    out_word,
   output logic [2:0]  out_num,
   output logic        out_last
);
   core_state_type state_ff, state_in;
   word_type   w_ff [16];        // message schedule window
   word_type   h_ff [8];
   word_type   v_ff [8];
   logic [5:0] fill_ff;
   logic [5:0] rnd_ff;
   logic [60:0] len_ff;
   logic       final_ff;         // this compression ends the message
   logic       pad_done_ff;      // message end seen, padding pending
   logic [2:0] emit_ff;
   word_type   t1, t2, wnew, wcur;
   logic [63:0] bits;

   assign bits = {len_ff, 3'b000};
   assign wcur = w_ff[0];
   assign wnew = sig1(w_ff[14]) + w_ff[9] + sig0(w_ff[1]) + w_ff[0];
   assign t1 = v_ff[7] + bsig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[rnd_ff] + wcur;
   assign t2 = bsig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));

   assign item_ready = (state_ff == ST_IDLE);
   assign out_valid  = (state_ff == ST_EMIT);
   assign out_word   = h_ff[emit_ff];
   assign out_num    = emit_ff;
   assign out_last   = (emit_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (item_valid) begin
            if (item.present && fill_ff == 6'd63) state_in = ST_ROUNDS;
            else if (item.last) state_in = ST_PAD;
         end
         ST_ROUNDS: if (rnd_ff == 6'd63) state_in = ST_FOLD;
         ST_FOLD:   state_in = final_ff ? ST_EMIT : (pad_done_ff ? ST_PAD : ST_IDLE);
         ST_PAD:    state_in = ST_LEN;
         ST_LEN:    state_in = ST_ROUNDS;
         ST_EMIT:   if (out_ready && emit_ff == 3'd7) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         len_ff      <= '0;
         rnd_ff      <= '0;
         final_ff    <= 1'b0;
         pad_done_ff <= 1'b0;
         emit_ff     <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: if (item_valid) begin
               final_ff    <= 1'b0;
               if (item.present) begin
                  w_ff[fill_ff[5:2]][8*(3-fill_ff[1:0]) +: 8] <= item.data;
                  fill_ff <= fill_ff + 6'd1;
                  len_ff  <= len_ff + 61'd1;
               end
               // a message end is remembered for the padding pass
               pad_done_ff <= item.last;
               rnd_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_ROUNDS: begin
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               v_ff[0] <= t1 + t2;
               v_ff[1] <= v_ff[0];
               v_ff[2] <= v_ff[1];
               v_ff[3] <= v_ff[2];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[5] <= v_ff[4];
               v_ff[6] <= v_ff[5];
               v_ff[7] <= v_ff[6];
               rnd_ff  <= rnd_ff + 6'd1;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               fill_ff <= '0;
            end
            ST_PAD: begin
               // first pass: 0x80 at the fill point, zeros after it;
               // second pass: the whole block is zero
               for (int b = 0; b < 64; b++) begin
                  if (!final_ff && rnd_ff == 6'd0) begin
                     if (b[5:0] == fill_ff)
                        w_ff[b/4][8*(3-b%4) +: 8] <= PAD_BYTE;
                     else if (b[5:0] > fill_ff)
                        w_ff[b/4][8*(3-b%4) +: 8] <= 8'd0;
                  end else if (rnd_ff != 6'd0) begin
                     w_ff[b/4][8*(3-b%4) +: 8] <= 8'd0;
                  end
               end
               for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            end
            ST_LEN: begin
               if (rnd_ff != 6'd0 || fill_ff < LEN_POS) begin
                  w_ff[14] <= bits[63:32];
                  w_ff[15] <= bits[31:0];
                  final_ff <= 1'b1;
               end
               rnd_ff <= '0;
            end
            ST_EMIT: if (out_ready) begin
               emit_ff <= emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
                  fill_ff <= '0;
                  len_ff  <= '0;
                  final_ff <= 1'b0;
                  pad_done_ff <= 1'b0;
               end
            end
            default: ;
         endcase
         // after folding a block that carried the pad byte but no length,
         // mark the second pass; a full data block leaves fill at zero
         if (state_ff == ST_FOLD && !final_ff && pad_done_ff && fill_ff != 6'd0)
            rnd_ff <= 6'd1;
      end
   end
endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// SHA-256 byte stream hasher, top level. Joins the input queue and the hashing core.
// Depends on sha256_pkg, sha256_fifo, sha256_core.
//
// One item carries a message byte and/or an end mark. Bytes fill a 64-byte block,
// one byte per cycle; each full block then runs 64 rounds, one per cycle, on a
// single round unit, and a fold step adds the working state into the hash. At
// the end mark the block pads with 0x80, zeros and the 64-bit bit length: a pad
// step, a length step, 64 rounds and a fold, twice over when the fill passes 55
// bytes and the length spills into a second block. Then it sends the eight digest
// words, word 0 first, one per cycle while the receiver is ready, and restarts. A
// four-deep queue ahead of the core keeps taking items while the core compresses;
// each item is held in a registered slot before the core sees it.
module sha256_byte_stream_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // message_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // digest_word[31:0], word_number[34:32], zero fill
   output logic        rsp_tlast    // last_word
);
   in_item_type wr_item, rd_item;
   logic        rd_valid, rd_ready;
   word_type    word;
   logic [2:0]  num;

   assign wr_item = '{data: req_tdata, present: req_tuser, last: req_tlast};

   sha256_fifo u_fifo (
      .clock, .reset,
      .wr_valid(req_tvalid), .wr_ready(req_tready), .wr_item(wr_item),
      .rd_valid(rd_valid), .rd_ready(rd_ready), .rd_item(rd_item)
   );

   sha256_core u_core (
      .clock, .reset,
      .item_valid(rd_valid), .item_ready(rd_ready), .item(rd_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_word(word), .out_num(num), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, num, word};

   // the last flag marks word seven only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7)))
      else $error("last flag off word seven");
   // word numbers advance by one on each delivered word
   a_seq: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> (rsp_tdata[34:32] ==
      $past(rsp_tdata[34:32]) + 3'd1))
      else $error("digest word order broken");
   // a stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("digest word dropped under stall");
endmodule

// ===== dv/sha256_byte_stream_hasher_test.sv =====
// Self-checking testbench for sha256_byte_stream_hasher: byte stream in, digest words out.
// Depends on sha256_pkg (types and constants) and the hasher RTL; predicts digests with its own SHA-256.
`timescale 1ns / 100ps

module sha256_byte_stream_hasher_test
   import sha256_pkg::*;
;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [7:0] data;
      logic       present;
      logic       last;
   } msg_item_type;

   typedef struct {
      logic [31:0] word;
      logic [2:0]  number;
      logic        last;
   } digest_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // message_byte
   logic        req_tuser = 1'b0; // byte_present
   logic        req_tlast = 1'b0; // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // digest_word[31:0], word_number[34:32], zero fill
   logic        rsp_tlast;        // last_word

   sha256_byte_stream_hasher u_dut (.*);

   always #5 clock = ~clock;

   // Predictor state
   logic [31:0] hash_acc [8];
   logic [7:0]  blk [64];
   int unsigned blk_fill;
   logic [60:0] msg_len;

   msg_item_type    pending_items [$];
   digest_item_type expected_words [$];

   int  errors = 0;
   int  send_idle_pct = 0;    // percent of cycles the sender holds off
   int  recv_stall_pct = 0;   // percent of cycles the receiver stalls
   longint cycle_count = 0;
   logic req_tready_seen = 1'b0;

   function automatic logic [31:0] ror(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
   endtask

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) hash_acc[i] = INIT_H[i];
      blk_fill = 0;
      msg_len = '0;
   endtask

   // Absorbs one accepted item; on the end mark pads and queues the digest.
   task automatic absorb_item(msg_item_type it);
      logic [63:0] bits;
      int unsigned f;
      digest_item_type d;
      if (it.present) begin
         blk[blk_fill] = it.data;
         blk_fill++;
         msg_len++;
         if (blk_fill == 64) begin
            compress_block();
            blk_fill = 0;
         end
      end
      if (!it.last) return;
      bits = {msg_len, 3'b000};
      f = blk_fill;
      blk[f] = PAD_BYTE;
      f++;
      if (f > 56) begin
         for (int i = f; i < 64; i++) blk[i] = 8'h00;
         compress_block();
         f = 0;
      end
      for (int i = f; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         d.word = hash_acc[i];
         d.number = 3'(i);
         d.last = (i == 7);
         expected_words.push_back(d);
      end
      hash_restart();
   endtask

   task automatic queue_item(logic [7:0] data, logic present, logic last);
      msg_item_type it;
      it.data = data;
      it.present = present;
      it.last = last;
      pending_items.push_back(it);
   endtask

   // Message of n random bytes; the final byte may carry the end mark itself,
   // or a bare end mark follows. Stray empty items are sprinkled in.
   task automatic queue_message(int n);
      bit joined;
      joined = (n > 0) && $urandom_range(1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(15) == 0) queue_item(8'($urandom), 1'b0, 1'b0);
         queue_item(8'($urandom), 1'b1, joined && (i == n - 1));
      end
      if (!joined) queue_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // Waits until every item is sent and accepted and every digest word is back.
   task automatic wait_drain();
      while (pending_items.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
   endtask

   // Driver: presents items at the falling edge, holds them until accepted.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               msg_item_type it;
               it = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= it.data;
               req_tuser <= it.present;
               req_tlast <= it.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: acceptance seen at the rising edge.
   always @(posedge clock) begin
      req_tready_seen <= 1'b0;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_tvalid && req_tready) begin
            msg_item_type it;
            it.data = req_tdata;
            it.present = req_tuser;
            it.last = req_tlast;
            absorb_item(it);
            req_tready_seen <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected digest word %h", rsp_tdata[31:0]);
               errors++;
            end else begin
               digest_item_type d;
               d = expected_words.pop_front();
               if (rsp_tdata[31:0] !== d.word) begin
                  $error("digest_word expected %h got %h", d.word, rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[34:32] !== d.number) begin
                  $error("word_number expected %0d got %0d", d.number, rsp_tdata[34:32]);
                  errors++;
               end
               if (rsp_tlast !== d.last) begin
                  $error("last_word expected %0d got %0d", d.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sha256_byte_stream_hasher_test: FAIL");
         $finish;
      end
   end

   initial begin
      hash_restart();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message, bare empty items, one byte with and without
      // joined end mark, extreme byte values, pad spill at 55/56 and 64 bytes.
      queue_item(8'hff, 1'b0, 1'b1);
      queue_item(8'h00, 1'b0, 1'b0);
      queue_item(8'hff, 1'b0, 1'b0);
      queue_item(8'h00, 1'b1, 1'b1);
      queue_item(8'hff, 1'b1, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      wait_drain();
      queue_message(55);
      queue_message(56);
      queue_message(64);
      wait_drain();

      // Random phases with different idle and stall rates.
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         for (int m = 0; m < 4; m++) begin
            queue_message($urandom_range(3) == 0 ? $urandom_range(20, 40)
                                                 : $urandom_range(0, 8));
            // sender holds off until the digests are all back
            if (ph == 1) wait_drain();
         end
         wait_drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0 && pending_items.size() == 0)
         $display("sha256_byte_stream_hasher_test: PASS");
      else
         $display("sha256_byte_stream_hasher_test: FAIL");
      $finish;
   end

endmodule
